// ----- hdl/blpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_pkg: shared types and constants
// Beat structs, press tracker states, event and mode command codes, register
// indexes and register reset values for the button long-press classifier.
// ----------------------------------------------------------------------------
package blpc_pkg;

	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_LONG_PRESS = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_IDLE_TIMEOUT = 1'b1;

	localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd3000;
	localparam logic [CFG_WIDTH-1:0] IDLE_TIMEOUT_RESET = 16'd5000;

	localparam logic [1:0] MODE_SETTING = 2'd1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_WAIT    = 2'd2,
		PH_LONG    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_PRESSED   = 3'd1,
		EV_SHORT_REL = 3'd2,
		EV_LONG      = 3'd3,
		EV_REPRESS   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		CMD_KEEP    = 2'd0,
		CMD_SETTING = 2'd1,
		CMD_STANDBY = 2'd2
	} mode_cmd_t;

	typedef struct packed {
		logic        button_level;
		logic [31:0] now_ms;
		logic [1:0]  mode_in;
		logic        blink_level;
	} req_beat_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic [1:0] mode_command;
		logic       pair_led;
		logic       indicator_led;
	} rsp_beat_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] long_press_ms;
		logic [CFG_WIDTH-1:0] idle_timeout_ms;
	} cfg_t;

endpackage

// ----- hdl/blpc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_cfg: configuration registers
// Holds the long-press hold time and the idle timeout, written through a
// plain write port.
// ----------------------------------------------------------------------------
module blpc_cfg
	import blpc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_wdata,
	output cfg_t                       cfg
);

	logic [CFG_WIDTH-1:0] long_press_q;
	logic [CFG_WIDTH-1:0] idle_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RESET;
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_LONG_PRESS: begin
					long_press_q <= cfg_wdata;
				end
				CFG_IDX_IDLE_TIMEOUT: begin
					idle_timeout_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.long_press_ms   = long_press_q;
	assign cfg.idle_timeout_ms = idle_timeout_q;

endmodule

// ----- hdl/blpc_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_tracker: press tracker
// Four-state press tracker with event time and pair-LED level; classifies
// one poll per step and updates its state on that step.
// ----------------------------------------------------------------------------
module blpc_tracker
	import blpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      step,
	input  req_beat_t beat,
	output rsp_beat_t result
);

	phase_t      phase_q;
	phase_t      phase_a;
	phase_t      phase_d;
	logic [31:0] event_time_q;
	logic [31:0] event_time_d;
	logic        pair_led_q;
	logic        pair_led_d;
	logic [31:0] diff;
	logic [31:0] wait_diff;
	logic        released;
	logic        setting;
	logic        et_load;
	logic        led;
	event_t      ev;
	mode_cmd_t   cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			event_time_q <= '0;
			pair_led_q   <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			event_time_q <= event_time_d;
			pair_led_q   <= pair_led_d;
		end
	end

	always_comb begin
		released   = beat.button_level;
		setting    = (beat.mode_in == MODE_SETTING);
		diff       = beat.now_ms - event_time_q;
		phase_a    = phase_q;
		ev         = EV_NONE;
		cmd        = CMD_KEEP;
		et_load    = 1'b0;
		pair_led_d = pair_led_q;

		if (released) begin
			if (!setting && phase_q == PH_LONG) begin
				setting = 1'b1;
				cmd     = CMD_SETTING;
				phase_a = PH_PRESSED;
			end else if (!setting && phase_q == PH_PRESSED) begin
				phase_a = PH_WAIT;
				et_load = 1'b1;
				ev      = EV_SHORT_REL;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					phase_a = PH_PRESSED;
					et_load = 1'b1;
					ev      = EV_PRESSED;
				end
				PH_WAIT: begin
					et_load = 1'b1;
					ev      = EV_REPRESS;
				end
				default: begin
					if (diff >= {16'd0, cfg.long_press_ms}) begin
						phase_a = PH_LONG;
						et_load = 1'b1;
						ev      = EV_LONG;
					end else begin
						ev = EV_PRESSED;
					end
				end
			endcase
		end

		// event time reloaded to now leaves a zero difference
		wait_diff = et_load ? 32'd0 : diff;
		phase_d   = phase_a;
		if (phase_a == PH_WAIT) begin
			if (wait_diff >= {16'd0, cfg.idle_timeout_ms}) begin
				cmd        = CMD_STANDBY;
				setting    = 1'b0;
				phase_d    = PH_IDLE;
				pair_led_d = 1'b0;
			end else begin
				pair_led_d = 1'b1;
			end
		end

		event_time_d = et_load ? beat.now_ms : event_time_q;

		if (phase_d == PH_WAIT || !released || ev == EV_PRESSED || ev == EV_SHORT_REL) begin
			led = 1'b1;
		end else if (ev == EV_LONG || setting) begin
			led = beat.blink_level;
		end else begin
			led = 1'b0;
		end

		result.event_code    = ev;
		result.mode_command  = cmd;
		result.pair_led      = pair_led_d;
		result.indicator_led = led;
	end

endmodule

// ----- hdl/button_long_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_long_press_classifier: top level
// Registers each poll, classifies it against the press tracker state and
// holds one result beat in an output register.
// ----------------------------------------------------------------------------
// path: request beat in the input register, then its result in the output register
// throughput: one poll per cycle while the output is not stalled; the tracker state
//   updates in the same cycle the poll leaves the input register, so the next poll sees it
// reset: tracker idle, event time zero, pair led off, long press 3000 ms,
//   idle timeout 5000 ms, both pipeline registers empty
module button_long_press_classifier
	import blpc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  req_beat_t                  req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output rsp_beat_t                  rsp_data,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]       cfg_wdata
);

	cfg_t      cfg;
	req_beat_t req_s1;
	logic      valid_s1;
	rsp_beat_t rsp_q;
	logic      rsp_valid_q;
	rsp_beat_t result;
	logic      out_free;
	logic      advance;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	blpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	blpc_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.beat   (req_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && rsp_valid_q))
		else $error("input stage stalled while not full");

	a_standby_clears_led: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.mode_command == CMD_STANDBY) |-> !rsp_data.pair_led)
		else $error("standby command with pair led on");

	a_setting_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.mode_command == CMD_SETTING) |->
		(rsp_data.event_code == EV_NONE))
		else $error("setting command together with an event");

endmodule
